### hdl/kct_pkg.sv
// ---------------------------------------------------------------------------
// kct_pkg
// shared types and constants of the keyed count table
// ---------------------------------------------------------------------------
package kct_pkg;

  localparam int KEY_W   = 31;
  localparam int CNT_W   = 31;
  localparam int CHAN_W  = 8;
  localparam int DELTA_W = 32;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // operation codes of the input word
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_QUERY = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  // request to the shared add/subtract unit
  typedef struct packed {
    logic             sub;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  // flag: overflow past COUNT_MAX on add, borrow (a < b) on subtract
  typedef struct packed {
    logic [CNT_W-1:0] res;
    logic             flag;
  } alu_rsp_t;

endpackage

### hdl/kct_alu.sv
// ---------------------------------------------------------------------------
// kct_alu
// shared count adder: saturation check on add, sufficiency check on subtract
// ---------------------------------------------------------------------------
module kct_alu
  import kct_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [CNT_W:0] opb;
  logic [CNT_W:0] sum;

  // subtract as a + ~b + 1 over one extra bit
  assign opb = req.sub ? ~{1'b0, req.b} : {1'b0, req.b};
  assign sum = {1'b0, req.a} + opb + {{CNT_W{1'b0}}, req.sub};

  // both operands are below 2^CNT_W, so the top bit is overflow or borrow
  assign rsp.res  = sum[CNT_W-1:0];
  assign rsp.flag = sum[CNT_W];

endmodule

### hdl/keyed_count_table.sv
// ---------------------------------------------------------------------------
// keyed_count_table
// bounded associative table of key and count pairs with add, delete and
// query operations and a change notice on every successful update
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_stall   operation, item_key, amount, channel
//  out_      output     out_valid/out_stall status, count, change notice
//
//  one word at a time: an accepted word scans the table one entry per cycle
//  through a single key comparator, stopping at the first key match;
//  the word passes the issue and compare stages of the scan, then the
//  update stage, which writes its result into the output register
//  rst_n is synchronous; it empties the table by clearing the valid bits,
//  key and count storage is not cleared and needs no clearing pass
//  a stalled result waits in the output register; the next word may be
//  accepted and scanned meanwhile, and its update waits for the register
//
module keyed_count_table
  import kct_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [KEY_W-1:0]          in_item_key,
  input  logic [CNT_W-1:0]          in_amount,
  input  logic [CHAN_W-1:0]         in_change_channel,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_status,
  output logic [CNT_W-1:0]          out_item_count,
  output logic                      out_notice_valid,
  output logic [KEY_W-1:0]          out_notice_key,
  output logic signed [DELTA_W-1:0] out_notice_delta,
  output logic [CHAN_W-1:0]         out_notice_channel
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state_r;

  // latched input word
  op_t                 op_r;
  logic [KEY_W-1:0]    key_r;
  logic [CNT_W-1:0]    amt_r;
  logic [CHAN_W-1:0]   chan_r;

  // scan pipeline: issue stage reads memory, compare stage checks the entry
  logic                issue_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic                cmp_vld_r;
  logic [IDX_W-1:0]    cmp_idx_r;

  // scan results
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [CNT_W-1:0]    hit_cnt_r;
  logic                free_r;
  logic [IDX_W-1:0]    free_idx_r;

  // table storage: valid bits in flops, key and count in memory
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] valid_nxt;
  entry_t              entry_mem [TABLE_DEPTH];
  entry_t              entry_rd_r;

  // output register
  logic                      out_valid_r;
  logic                      out_status_r;
  logic [CNT_W-1:0]          out_count_r;
  logic                      out_nvalid_r;
  logic [KEY_W-1:0]          out_nkey_r;
  logic signed [DELTA_W-1:0] out_ndelta_r;
  logic [CHAN_W-1:0]         out_nchan_r;

  // update stage signals
  alu_req_t                  alu_req;
  alu_rsp_t                  alu_rsp;
  logic                      args_ok;
  logic [CNT_W-1:0]          cur_cnt;
  logic                      ex_status;
  logic [CNT_W-1:0]          ex_count;
  logic                      ex_notice;
  logic signed [DELTA_W-1:0] ex_delta;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  entry_t                    wr_data;
  logic                      exec_go;
  logic                      mem_we;
  logic                      slot_match;

  assign in_stall = (state_r != ST_IDLE);

  // compare stage: entry is a hit only if its slot is in use
  assign slot_match = valid_r[cmp_idx_r] && (entry_rd_r.key == key_r);

  // update fires only when the output register can take the result
  assign exec_go = (state_r == ST_EXEC) && !(out_valid_r && out_stall);
  assign mem_we  = wr_en && exec_go;

  // current count of the key, zero if absent
  assign cur_cnt = hit_r ? hit_cnt_r : '0;
  assign args_ok = (key_r != '0) && (amt_r != '0);

  // one adder serves both the saturating add and the checked subtract
  assign alu_req.sub = (op_r == OP_DEL);
  assign alu_req.a   = cur_cnt;
  assign alu_req.b   = amt_r;

  kct_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // result and table update of the word in the update stage
  always_comb begin
    ex_status = 1'b1;
    ex_count  = cur_cnt;
    ex_notice = 1'b0;
    ex_delta  = '0;
    wr_en     = 1'b0;
    wr_idx    = hit_idx_r;
    wr_data   = '{key: key_r, count: alu_rsp.res};
    valid_nxt = valid_r;
    unique case (op_r)
      OP_ADD: begin
        if (args_ok) begin
          if (hit_r) begin
            // existing key: add with saturation
            ex_count      = alu_rsp.flag ? COUNT_MAX : alu_rsp.res;
            wr_en         = 1'b1;
            wr_data.count = ex_count;
            ex_status     = 1'b0;
          end else if (free_r) begin
            // new key into the lowest free slot
            ex_count          = amt_r;
            wr_en             = 1'b1;
            wr_idx            = free_idx_r;
            wr_data.count     = amt_r;
            valid_nxt[free_idx_r] = 1'b1;
            ex_status         = 1'b0;
          end
          if (!ex_status) begin
            ex_notice = 1'b1;
            ex_delta  = $signed({1'b0, amt_r});
          end
        end
      end
      OP_DEL: begin
        // borrow flag set means the stored count is too small
        if (args_ok && hit_r && !alu_rsp.flag) begin
          ex_count  = alu_rsp.res;
          ex_status = 1'b0;
          ex_notice = 1'b1;
          ex_delta  = -$signed({1'b0, amt_r});
          if (alu_rsp.res == '0) begin
            valid_nxt[hit_idx_r] = 1'b0;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        ex_status = 1'b0;
      end
      OP_RSVD: begin
        ex_status = 1'b1;
      end
    endcase
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[wr_idx] <= wr_data;
    end
    if (issue_r) begin
      entry_rd_r <= entry_mem[scan_idx_r];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces the old one, otherwise a taken word clears
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r       <= op_t'(in_operation);
            key_r      <= in_item_key;
            amt_r      <= in_amount;
            chan_r     <= in_change_channel;
            scan_idx_r <= '0;
            issue_r    <= 1'b1;
            cmp_vld_r  <= 1'b0;
            hit_r      <= 1'b0;
            free_r     <= 1'b0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld_r <= issue_r;
          cmp_idx_r <= scan_idx_r;
          if (issue_r) begin
            scan_idx_r <= scan_idx_r + 1'b1;
            if (scan_idx_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end
          end
          if (cmp_vld_r) begin
            // first free slot in index order
            if (!valid_r[cmp_idx_r] && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= cmp_idx_r;
            end
            if (slot_match) begin
              hit_r     <= 1'b1;
              hit_idx_r <= cmp_idx_r;
              hit_cnt_r <= entry_rd_r.count;
              state_r   <= ST_EXEC;
            end else if (cmp_idx_r == LAST_IDX) begin
              state_r <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            out_status_r <= ex_status;
            out_count_r  <= ex_count;
            out_nvalid_r <= ex_notice;
            out_nkey_r   <= ex_notice ? key_r : '0;
            out_ndelta_r <= ex_delta;
            out_nchan_r  <= ex_notice ? chan_r : '0;
            valid_r      <= valid_nxt;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_item_count     = out_count_r;
  assign out_notice_valid   = out_nvalid_r;
  assign out_notice_key     = out_nkey_r;
  assign out_notice_delta   = out_ndelta_r;
  assign out_notice_channel = out_nchan_r;

endmodule

### hdl/kct_checker.sv
// ---------------------------------------------------------------------------
// kct_checker
// port level checks of the keyed count table, bound to the top level
// ---------------------------------------------------------------------------
module kct_checker
  import kct_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_status,
  input logic [CNT_W-1:0]          out_item_count,
  input logic                      out_notice_valid,
  input logic [KEY_W-1:0]          out_notice_key,
  input logic signed [DELTA_W-1:0] out_notice_delta,
  input logic [CHAN_W-1:0]         out_notice_channel
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item_count)
      && $stable(out_status) && $stable(out_notice_delta))
    else $error("stalled result word changed");

  // one word in flight: the input stalls right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a change notice only comes with success
  a_notice_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notice_valid |-> !out_status && out_notice_delta != '0)
    else $error("notice on failed operation or with zero delta");

  // without a notice the notice fields are zero
  a_notice_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_notice_valid |-> out_notice_key == '0
      && out_notice_delta == '0 && out_notice_channel == '0)
    else $error("notice fields set without notice");

endmodule

bind keyed_count_table kct_checker u_kct_checker (.*);
